// ===== sv/ssk_pkg.sv =====
// shared types and constants of the space-saving top-k tracker
package ssk_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int KEY_W = 64;
	localparam int LEN_W = 4;
	localparam int CNT_W = 32;
	localparam int CAP_W = 7;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 72;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] err;
	} ssk_entry_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic match;
		logic update;
	} ssk_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_MATCH  = 3'b010,
		S_UPDATE = 3'b100
	} ssk_state_t;

endpackage

// ===== sv/ssk_ctrl.sv =====
// controller state machine of the top-k tracker
module ssk_ctrl
	import ssk_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ssk_cmd_t  cmd
);

	ssk_state_t state_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.match  = (state_q == S_MATCH);
		cmd.update = (state_q == S_UPDATE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MATCH;
				end
				S_MATCH: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					// hold here until the output register has room
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.update) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/ssk_datapath.sv =====
// ranked entry cells, match logic and result register of the top-k tracker
module ssk_datapath
	import ssk_pkg::*;
#(
	parameter int N = MAX_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssk_cmd_t              cmd,
	input  logic                  cfg_we,
	input  logic [CAP_W-1:0]      cfg_wdata,
	input  logic [IN_DATA_W-1:0]  in_data,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int IDX_W = (N > 1) ? $clog2(N) : 1;
	localparam int OCC_W = $clog2(N + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	// cells in rank order, rank 0 lowest
	ssk_entry_t             entry_q [N];
	ssk_entry_t             entry_d [N];
	logic [OCC_W-1:0]       occ_q;
	logic [CAP_W-1:0]       cap_q;
	logic [KEY_W-1:0]       key_q;
	logic [LEN_W-1:0]       len_q;
	logic                   hit_q;
	logic                   ev_q;
	logic [OCC_W-1:0]       r_q;
	logic [CNT_W-1:0]       c_q;
	logic [CNT_W-1:0]       e_q;
	logic [OUT_DATA_W-1:0]  out_q;

	logic [N-1:0]           match;
	logic [IDX_W-1:0]       enc;
	logic [CNT_W-1:0]       sel_cnt;
	logic [CNT_W-1:0]       sel_err;
	logic [CMP_W-1:0]       eff_cap;
	logic                   full;
	logic                   any_hit;
	logic [CNT_W-1:0]       cnew;
	logic [CNT_W-1:0]       enew;
	ssk_entry_t             nrec;
	logic [N:0]             lt;
	logic [N-1:0]           below;

	function automatic logic [KEY_W-1:0] mask_key(logic [KEY_W-1:0] k, logic [LEN_W-1:0] l);
		logic [KEY_W-1:0] m;
		m = '0;
		for (int b = 0; b < KEY_W / 8; b++) begin
			if (LEN_W'(b) < l) m[b*8 +: 8] = 8'hFF;
		end
		return k & m;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

	// match stage
	always_comb begin
		match   = '0;
		enc     = '0;
		sel_cnt = '0;
		sel_err = '0;
		for (int j = 0; j < N; j++) begin
			match[j] = (OCC_W'(j) < occ_q) && (entry_q[j].key == key_q)
				&& (entry_q[j].len == len_q);
			if (match[j]) begin
				enc     = enc | IDX_W'(j);
				sel_cnt = sel_cnt | entry_q[j].cnt;
				sel_err = sel_err | entry_q[j].err;
			end
		end
		any_hit = |match;
		if (cap_q == '0) eff_cap = CMP_W'(1);
		else if (CMP_W'(cap_q) > CMP_W'(N)) eff_cap = CMP_W'(N);
		else eff_cap = CMP_W'(cap_q);
		full = CMP_W'(occ_q) >= eff_cap;
	end

	// update stage
	always_comb begin
		cnew = (hit_q || ev_q) ? sat_inc(c_q) : CNT_W'(1);
		enew = ev_q ? c_q : (hit_q ? e_q : '0);
		nrec = '{key: key_q, len: len_q, cnt: cnew, err: enew};
		lt   = '0;
		for (int j = 0; j < N; j++) begin
			lt[j] = (OCC_W'(j) < occ_q) && (entry_q[j].cnt < cnew);
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_cell
		ssk_entry_t up_e;
		ssk_entry_t dn_e;
		logic       j_lt_r;
		logic       is_q;
		if (j + 1 < N) begin : g_up
			assign up_e = entry_q[j+1];
		end else begin : g_top
			assign up_e = entry_q[j];
		end
		if (j > 0) begin : g_dn
			assign dn_e = entry_q[j-1];
			assign is_q = !below[j] && below[j-1];
		end else begin : g_bot
			assign dn_e = entry_q[j];
			assign is_q = !below[j];
		end
		assign j_lt_r   = OCC_W'(j) < r_q;
		assign below[j] = j_lt_r ? lt[j] : lt[j+1];
		always_comb begin
			if (below[j]) entry_d[j] = j_lt_r ? entry_q[j] : up_e;
			else if (is_q) entry_d[j] = nrec;
			else if (OCC_W'(j) <= r_q) entry_d[j] = dn_e;
			else entry_d[j] = entry_q[j];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q <= in_data[KEY_W +: LEN_W];
			key_q <= mask_key(in_data[KEY_W-1:0], in_data[KEY_W +: LEN_W]);
		end
		if (cmd.match) begin
			hit_q <= any_hit;
			ev_q  <= !any_hit && full;
			r_q   <= any_hit ? OCC_W'(enc) : (full ? '0 : occ_q);
			c_q   <= any_hit ? sel_cnt : entry_q[0].cnt;
			e_q   <= sel_err;
		end
		if (cmd.update) begin
			for (int j = 0; j < N; j++) entry_q[j] <= entry_d[j];
			out_q <= {6'b0, ev_q, hit_q, enew, cnew};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cap_q <= CAP_W'(N > 127 ? 127 : N);
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.update && !hit_q && !ev_q) occ_q <= occ_q + OCC_W'(1);
		end
	end

	assign out_data = out_q;

endmodule

// ===== sv/space_saving_top_k.sv =====
// top level of the space-saving top-k tracker
// Space-saving heavy-hitter tracker. Each input transaction carries one key
// occurrence (key bytes and length); each produces exactly one output
// transaction with the key's count after the update, its error bound and
// the hit and eviction flags. The monitored keys sit in a row of cells kept
// in rank order (ascending count, newest lowest among ties); all cells are
// compared at once and the row shifts by one place around the removed and
// inserted rank. An item passes accept, a parallel match over the cells,
// then the compare-and-shift update that also loads the output register
// and waits while a held result is not yet taken; the next item is accepted
// the cycle after the update, so only one item is in flight at a time.
// The capacity register is written from cfg_wdata when cfg_we is high and
// should only be changed while no item is in flight.
module space_saving_top_k
	import ssk_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CAP_W-1:0]      cfg_wdata,     // capacity
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[63:0], key_len[67:64], zero pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // count[31:0], error[63:32],
	                                             // was_hit[64], evicted[65], zero pad
);

	ssk_cmd_t  cmd;

	// sequencing of accept, match and update
	ssk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// ranked cells and result register
	ssk_datapath #(
		.N (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== sv/ssk_checker.sv =====
// port-level checks of the top-k tracker and their binding
module ssk_checker
	import ssk_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one item at a time: busy right after a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	// every reported count is at least one
	a_cnt_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:0] != '0)
		else $error("zero count reported");

	// a fresh key enters at count one with no error
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[64] && !m_axis_tdata[65]
		|-> m_axis_tdata[31:0] == 32'd1 && m_axis_tdata[63:32] == '0)
		else $error("new entry with wrong count or error");

	// a hit never evicts
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[64] && m_axis_tdata[65]))
		else $error("hit and eviction together");

endmodule

bind space_saving_top_k ssk_checker u_ssk_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
